@@ hw/rtl/bfar_pkg.sv @@
`default_nettype none
package bfar_pkg;

  localparam int unsigned NumComp = 9;
  localparam int unsigned CompW   = 16;
  localparam int unsigned CordW   = 28;
  localparam int unsigned Iters   = 16;
  localparam int unsigned ItW     = 4;

  localparam logic signed [CordW-1:0] CordGain = 28'sd10188014;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;
  localparam logic signed [16:0] TurnSteps = 17'sd23040;
  localparam logic [14:0] QuadSteps = 15'd5760;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;
  localparam logic [1:0] AxisNone = 2'd3;

  typedef logic signed [CompW-1:0] comp_t;

  function automatic logic signed [CordW-1:0] atan_lut(input logic [ItW-1:0] i);
    logic signed [CordW-1:0] r;
    case (i)
      4'd0: r = 28'sd737280;
      4'd1: r = 28'sd435242;
      4'd2: r = 28'sd229970;
      4'd3: r = 28'sd116736;
      4'd4: r = 28'sd58595;
      4'd5: r = 28'sd29326;
      4'd6: r = 28'sd14667;
      4'd7: r = 28'sd7334;
      4'd8: r = 28'sd3667;
      4'd9: r = 28'sd1833;
      4'd10: r = 28'sd917;
      4'd11: r = 28'sd458;
      4'd12: r = 28'sd229;
      4'd13: r = 28'sd115;
      4'd14: r = 28'sd57;
      default: r = 28'sd29;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bfar_if.sv @@
`default_nettype none
interface bfar_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        axis;
  logic signed [15:0] angle;
  modport source (output valid, axis, angle, input ready);
  modport sink   (input valid, axis, angle, output ready);
endinterface

interface bfar_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_axis_x, x_axis_y, x_axis_z;
  logic signed [15:0] y_axis_x, y_axis_y, y_axis_z;
  logic signed [15:0] z_axis_x, z_axis_y, z_axis_z;
  modport source (output valid, x_axis_x, x_axis_y, x_axis_z, y_axis_x, y_axis_y,
                  y_axis_z, z_axis_x, z_axis_y, z_axis_z, input ready);
  modport sink   (input valid, x_axis_x, x_axis_y, x_axis_z, y_axis_x, y_axis_y,
                  y_axis_z, z_axis_x, z_axis_y, z_axis_z, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bfar_cordic.sv @@
`default_nettype none
// Sequential CORDIC: one micro-rotation per cycle, one shared shifter pair.
module bfar_cordic (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic signed [15:0] angle_i,
  output logic      done_o,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);
  import bfar_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0] st_q, st_d;
  logic [ItW-1:0] it_q, it_d;
  logic [1:0] quad_q, quad_d;
  logic signed [CordW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [15:0] s_q, s_d, c_q, c_d;

  // angle reduction: a = angle mod turn, then quadrant by compare/subtract
  logic signed [16:0] a0, a1;
  logic [14:0] r0;
  logic [1:0]  q0;
  logic signed [CordW-1:0] xs, ys;
  logic signed [15:0] cq, sq;

  function automatic logic signed [15:0] to_q14(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] t;
    logic signed [CordW-11:0] r;
    t = v + 28'sd512;
    r = (CordW-10)'(t >>> 10);
    if (r > 18'sd16384) r = 18'sd16384;
    if (r < -18'sd16384) r = -18'sd16384;
    return r[15:0];
  endfunction

  always_comb begin
    a0 = {angle_i[15], angle_i};
    if (a0 >= TurnSteps) a0 = a0 - TurnSteps;
    if (a0 < 17'sd0) a0 = a0 + TurnSteps;
    if (a0 < 17'sd0) a0 = a0 + TurnSteps;
    a1 = a0;
    q0 = 2'd0;
    if (a1 >= 17'sd17280) begin
      q0 = 2'd3; a1 = a1 - 17'sd17280;
    end else if (a1 >= 17'sd11520) begin
      q0 = 2'd2; a1 = a1 - 17'sd11520;
    end else if (a1 >= 17'sd5760) begin
      q0 = 2'd1; a1 = a1 - 17'sd5760;
    end
    r0 = a1[14:0];
  end

  always_comb begin
    xs = x_q >>> it_q;
    ys = y_q >>> it_q;
    cq = to_q14(x_q);
    sq = to_q14(y_q);
  end

  always_comb begin
    st_d = st_q; it_d = it_q; quad_d = quad_q;
    x_d = x_q; y_d = y_q; z_d = z_q; s_d = s_q; c_d = c_q;
    done_o = 1'b0;
    case (st_q)
      StIdle: begin
        if (start_i) begin
          x_d = CordGain; y_d = '0;
          z_d = CordW'({r0, 8'd0});
          quad_d = q0; it_d = '0; st_d = StRun;
        end
      end
      StRun: begin
        if (!z_q[CordW-1]) begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - atan_lut(it_q);
        end else begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + atan_lut(it_q);
        end
        it_d = it_q + 1'b1;
        if (it_q == ItW'(Iters - 1)) st_d = StOut;
      end
      StOut: begin
        case (quad_q)
          2'd0: begin s_d = sq; c_d = cq; end
          2'd1: begin s_d = cq; c_d = -sq; end
          2'd2: begin s_d = -sq; c_d = -cq; end
          default: begin s_d = -cq; c_d = sq; end
        endcase
        done_o = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  assign sin_o = s_q;
  assign cos_o = c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      it_q <= '0;
    end else begin
      st_q <= st_d;
      it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
    s_q <= s_d; c_q <= c_d;
  end
endmodule
`default_nettype wire

@@ hw/rtl/basis_frame_axis_rotation.sv @@
`default_nettype none
// From input beat to output beat: 16 CORDIC steps, 1 quadrant fix-up, 12 multiply steps,
// then the output register (axis code 3: straight to the output register).
// One beat at a time: a new beat is taken only once the last has left the output;
// the CORDIC loop and the single 16x16 multiplier set how fast beats go through.
// Output is a register; input is held off until taken.
// Reset (async, active low): frame returns to x=(-1,0,0), y=(0,0,1), z=(0,1,0).
module basis_frame_axis_rotation (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bfar_in_if.sink   in_i,
  bfar_out_if.source out_o
);
  import bfar_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StTrig = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  logic [2:0] st_q, st_d;
  comp_t frame_q [NumComp];
  comp_t frame_d [NumComp];
  logic [1:0] axis_q, axis_d;
  logic [3:0] step_q, step_d;  // 12 products: vector v, pair product k
  logic signed [33:0] acc_q, acc_d;
  comp_t a_q, a_d, b_q, b_d;   // snapshot of pair for current vector
  logic cord_start, cord_done;
  comp_t sin_w, cos_w;

  bfar_cordic u_cordic (
    .clk_i, .rst_ni,
    .start_i(cord_start), .angle_i(in_i.angle),
    .done_o(cord_done), .sin_o(sin_w), .cos_o(cos_w)
  );

  // component index of pair members
  logic [1:0] ia, ib, vec;
  logic [1:0] k;
  logic [3:0] idx_a, idx_b;
  always_comb begin
    case (axis_q)
      AxisX: begin ia = 2'd2; ib = 2'd1; end
      AxisY: begin ia = 2'd0; ib = 2'd2; end
      default: begin ia = 2'd0; ib = 2'd1; end
    endcase
    vec = step_q[3:2];
    k   = step_q[1:0];
    idx_a = 4'(vec * 3) + 4'(ia);
    idx_b = 4'(vec * 3) + 4'(ib);
  end

  // shared multiplier; order per vector: c*a, -s*b (write a'), s*a, c*b (write b')
  comp_t mx, my;
  logic signed [31:0] prod;
  logic signed [33:0] sum, rnd;
  logic signed [19:0] sh;
  comp_t sat;
  always_comb begin
    case (k)
      2'd0: begin mx = cos_w; my = frame_q[idx_a]; end
      2'd1: begin mx = -sin_w; my = b_q; end
      2'd2: begin mx = sin_w; my = a_q; end
      default: begin mx = cos_w; my = b_q; end
    endcase
    prod = mx * my;
    sum = acc_q + 34'(prod);
    rnd = sum + 34'sd8192;
    sh  = 20'(rnd >>> 14);
    if (sh > 20'sd32767) sat = 16'sh7fff;
    else if (sh < -20'sd32768) sat = 16'sh8000;
    else sat = sh[15:0];
  end

  always_comb begin
    st_d = st_q; axis_d = axis_q; step_d = step_q;
    acc_d = acc_q; a_d = a_q; b_d = b_q;
    for (int i = 0; i < NumComp; i++) frame_d[i] = frame_q[i];
    cord_start = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_i.valid) begin
          axis_d = in_i.axis;
          if (in_i.axis == AxisNone) st_d = StOut;
          else begin
            cord_start = 1'b1;
            st_d = StTrig;
          end
        end
      end
      StTrig: begin
        if (cord_done) begin
          step_d = '0; acc_d = '0; st_d = StMul;
        end
      end
      StMul: begin
        if (k == 2'd0) begin
          a_d = frame_q[idx_a]; b_d = frame_q[idx_b];
        end
        if (k == 2'd0 || k == 2'd2) acc_d = 34'(prod);
        else begin
          acc_d = '0;
          if (k == 2'd1) frame_d[idx_a] = sat;
          else frame_d[idx_b] = sat;
        end
        step_d = step_q + 1'b1;
        if (step_q == 4'd11) st_d = StOut;
      end
      StOut: begin
        if (out_o.ready) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  assign in_i.ready  = (st_q == StIdle);
  assign out_o.valid = (st_q == StOut);
  assign out_o.x_axis_x = frame_q[0];
  assign out_o.x_axis_y = frame_q[1];
  assign out_o.x_axis_z = frame_q[2];
  assign out_o.y_axis_x = frame_q[3];
  assign out_o.y_axis_y = frame_q[4];
  assign out_o.y_axis_z = frame_q[5];
  assign out_o.z_axis_x = frame_q[6];
  assign out_o.z_axis_y = frame_q[7];
  assign out_o.z_axis_z = frame_q[8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      step_q <= '0;
      frame_q[0] <= -OneQ14;
      frame_q[1] <= '0;
      frame_q[2] <= '0;
      frame_q[3] <= '0;
      frame_q[4] <= '0;
      frame_q[5] <= OneQ14;
      frame_q[6] <= '0;
      frame_q[7] <= OneQ14;
      frame_q[8] <= '0;
    end else begin
      st_q <= st_d;
      step_q <= step_d;
      for (int i = 0; i < NumComp; i++) frame_q[i] <= frame_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q <= axis_d;
    acc_q <= acc_d;
    a_q <= a_d;
    b_q <= b_d;
  end
endmodule
`default_nettype wire
